[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the card set table controller.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CHST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CHST_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CHST_ASSERT(lbl, clk, rstn, prop, msg)
`define CHST_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[sv/chst_pkg.sv]
// ---------------------------------------------------------------------------
// Card set table package
// Widths, codes and the control and status bundles of the card set table.
// ---------------------------------------------------------------------------
package chst_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned PTR_W    = IDX_W + 1;
  localparam int unsigned CARDS    = 4;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned CARD_W   = 16;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned ENT_W    = 8;
  localparam int unsigned CTOT_W   = 10;

  // A pointer with its top bit set is the null link.
  localparam logic [PTR_W-1:0] NIL = {1'b1, {IDX_W{1'b0}}};

  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_GET      = 3'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [ST_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOFREE  = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]             region;
    logic [CARDS-1:0]             valid;
    logic [CARDS-1:0][CARD_W-1:0] cards;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic accept;
    logic head;
    logic walk;
    logic miss;
    logic pop;
    logic del2;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic in_short;
    logic head_null;
    logic match;
    logic next_null;
    logic is_add;
    logic is_del;
    logic free_null;
  } sts_t;

endpackage

[sv/chst_if.sv]
// ---------------------------------------------------------------------------
// Card set table channels
// Request and response channels with valid and ready handshakes.
// ---------------------------------------------------------------------------
interface chst_req_if;
  import chst_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  region;
  logic [CARD_W-1:0] card;
  modport source (output valid, operation, region, card, input ready);
  modport sink   (input valid, operation, region, card, output ready);
endinterface

interface chst_rsp_if;
  import chst_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  card_count;
  logic [CARD_W-1:0] card_0;
  logic [CARD_W-1:0] card_1;
  logic [CARD_W-1:0] card_2;
  logic [CARD_W-1:0] card_3;
  logic [ENT_W-1:0]  entries_used;
  logic [CTOT_W-1:0] cards_used;
  modport source (output valid, status, card_count, card_0, card_1, card_2, card_3,
                  entries_used, cards_used, input ready);
  modport sink   (input valid, status, card_count, card_0, card_1, card_2, card_3,
                  entries_used, cards_used, output ready);
endinterface

[sv/chained_hash_card_set_table_top.sv]
// ---------------------------------------------------------------------------
// Chained hash card set table
// Region-keyed hash table of small card sets with a free-list allocator.
// ---------------------------------------------------------------------------
// The request channel carries an operation, a region and a card; each
// accepted beat produces exactly one response beat with a status, the card
// set of a get, and the entry and card counts after the operation.
// One item is in work at a time. Clear and unknown operations go from
// acceptance straight to the response step. Other operations read the
// bucket head, then read one chain entry per step while walking the chain,
// then load the response. A miss step is added when the region is not
// found, a free list link step for a delete and a next link read step for
// an add that pops the free list. The entry memories have one registered
// read port, which sets the one-entry-per-cycle walk.
// The response sits in an output register; while the receiver stalls the
// finished result waits there and the next result waits in its final step.
// Reset empties all buckets, the free list and the counts at once; entry
// memories need no clearing pass.
// ---------------------------------------------------------------------------
module chained_hash_card_set_table_top (
  input logic       clk_i,
  input logic       rst_ni,
  chst_req_if.sink  req_i,
  chst_rsp_if.source rsp_o
);
  import chst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  chst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  chst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_operation_i (req_i.operation),
    .in_region_i    (req_i.region),
    .in_card_i      (req_i.card),
    .status_o       (rsp_o.status),
    .card_count_o   (rsp_o.card_count),
    .card_0_o       (rsp_o.card_0),
    .card_1_o       (rsp_o.card_1),
    .card_2_o       (rsp_o.card_2),
    .card_3_o       (rsp_o.card_3),
    .entries_used_o (rsp_o.entries_used),
    .cards_used_o   (rsp_o.cards_used)
  );
endmodule

[sv/chst_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module chst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[sv/chst_ctrl.sv]
// ---------------------------------------------------------------------------
// Card set table controller
// Sequences the head read, the chain walk and the update steps of one item.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  chst_pkg::sts_t sts_i,
  output chst_pkg::cmd_t cmd_o
);
  import chst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HEAD = 7'b0000010,
    S_WALK = 7'b0000100,
    S_MISS = 7'b0001000,
    S_POP  = 7'b0010000,
    S_DEL2 = 7'b0100000,
    S_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept    = accept;
    cmd_o.head      = (state_q == S_HEAD);
    cmd_o.walk      = (state_q == S_WALK);
    cmd_o.miss      = (state_q == S_MISS);
    cmd_o.pop       = (state_q == S_POP);
    cmd_o.del2      = (state_q == S_DEL2);
    cmd_o.resp_load = load;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = sts_i.in_short ? S_RESP : S_HEAD;
        end
      end
      S_HEAD: state_d = sts_i.head_null ? S_MISS : S_WALK;
      S_WALK: begin
        if (sts_i.match) begin
          state_d = sts_i.is_del ? S_DEL2 : S_RESP;
        end else if (sts_i.next_null) begin
          state_d = S_MISS;
        end
      end
      S_MISS: state_d = (sts_i.is_add && !sts_i.free_null) ? S_POP : S_RESP;
      S_POP:  state_d = S_RESP;
      S_DEL2: state_d = S_RESP;
      S_RESP: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CHST_ASSERT(a_load_shows_beat, clk_i, rst_ni, load |=> out_valid_q, "result beat not shown")
  `CHST_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, accept |=> (state_q != S_IDLE),
               "accepted item did not start")
  `CHST_ASSERT(a_pop_after_miss, clk_i, rst_ni, (state_q == S_POP) |-> ($past(state_q) == S_MISS),
               "free list pop without a miss")
endmodule

[sv/chst_dp.sv]
// ---------------------------------------------------------------------------
// Card set table datapath
// Bucket heads, entry memories, allocator, counters and result registers.
// ---------------------------------------------------------------------------
module chst_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  chst_pkg::cmd_t            cmd_i,
  output chst_pkg::sts_t            sts_o,
  input  logic [chst_pkg::OP_W-1:0]   in_operation_i,
  input  logic [chst_pkg::KEY_W-1:0]  in_region_i,
  input  logic [chst_pkg::CARD_W-1:0] in_card_i,
  output logic [chst_pkg::ST_W-1:0]   status_o,
  output logic [chst_pkg::CNT_W-1:0]  card_count_o,
  output logic [chst_pkg::CARD_W-1:0] card_0_o,
  output logic [chst_pkg::CARD_W-1:0] card_1_o,
  output logic [chst_pkg::CARD_W-1:0] card_2_o,
  output logic [chst_pkg::CARD_W-1:0] card_3_o,
  output logic [chst_pkg::ENT_W-1:0]  entries_used_o,
  output logic [chst_pkg::CTOT_W-1:0] cards_used_o
);
  import chst_pkg::*;

  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  region_q;
  logic [CARD_W-1:0] card_q;
  logic [PTR_W-1:0]  head_q, free_q, free_d, prev_q;
  logic [IDX_W-1:0]  cur_q, bump_q, bump_d;
  logic [CAPACITY-1:0] bvalid_q, bvalid_d;
  logic [ENT_W-1:0]  ent_q, ent_d;
  logic [CTOT_W-1:0] ctot_q, ctot_d;
  logic [ST_W-1:0]   res_status_q, res_status_d;
  logic [CNT_W-1:0]  res_count_q, res_count_d;
  logic [CARDS-1:0][CARD_W-1:0] res_cards_q, res_cards_d;
  logic [ST_W-1:0]   out_status_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [CARDS-1:0][CARD_W-1:0] out_cards_q;
  logic [ENT_W-1:0]  out_ent_q;
  logic [CTOT_W-1:0] out_ctot_q;

  logic [IDX_W-1:0]  bucket_q;
  logic [PTR_W-1:0]  head_rdata, head_val, next_rdata;
  logic [ENTRY_W-1:0] data_rdata;
  entry_t            ent_rd, ent_wdata;
  logic              head_we, next_we, data_we;
  logic [IDX_W-1:0]  head_waddr, next_waddr, data_waddr, entry_raddr;
  logic [PTR_W-1:0]  head_wdata, next_wdata;
  logic              match, holds, has_empty, bump_ok;
  logic [$clog2(CARDS)-1:0] empty_k;
  logic [CNT_W-1:0]  pop_cnt;
  logic              ins;
  logic [IDX_W-1:0]  ins_idx;

  assign bucket_q = region_q[IDX_W-1:0];
  assign head_val = bvalid_q[bucket_q] ? head_rdata : NIL;
  assign ent_rd   = entry_t'(data_rdata);
  assign match    = (ent_rd.region == region_q);
  assign bump_ok  = (bump_q != IDX_W'(CAPACITY - 1));

  always_comb begin
    holds     = 1'b0;
    has_empty = 1'b0;
    empty_k   = '0;
    pop_cnt   = '0;
    for (int k = CARDS - 1; k >= 0; k--) begin
      if (ent_rd.valid[k] && ent_rd.cards[k] == card_q) begin
        holds = 1'b1;
      end
      if (!ent_rd.valid[k]) begin
        has_empty = 1'b1;
        empty_k   = ($clog2(CARDS))'(k);
      end
      pop_cnt = pop_cnt + CNT_W'(ent_rd.valid[k]);
    end
  end

  always_comb begin
    sts_o.in_short  = (in_operation_i == OP_CLEAR) || (in_operation_i > OP_CLEAR);
    sts_o.head_null = head_val[IDX_W];
    sts_o.match     = match;
    sts_o.next_null = next_rdata[IDX_W];
    sts_o.is_add    = (op_q == OP_ADD);
    sts_o.is_del    = (op_q == OP_DELETE);
    sts_o.free_null = free_q[IDX_W];
  end

  always_comb begin
    if (cmd_i.head) begin
      entry_raddr = head_val[IDX_W-1:0];
    end else if (cmd_i.walk) begin
      entry_raddr = next_rdata[IDX_W-1:0];
    end else if (cmd_i.miss) begin
      entry_raddr = free_q[IDX_W-1:0];
    end else begin
      entry_raddr = cur_q;
    end
  end

  always_comb begin
    bvalid_d     = bvalid_q;
    free_d       = free_q;
    bump_d       = bump_q;
    ent_d        = ent_q;
    ctot_d       = ctot_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_cards_d  = res_cards_q;
    head_we      = 1'b0;
    head_waddr   = bucket_q;
    head_wdata   = next_rdata;
    next_we      = 1'b0;
    next_waddr   = prev_q[IDX_W-1:0];
    next_wdata   = next_rdata;
    data_we      = 1'b0;
    data_waddr   = cur_q;
    ent_wdata    = ent_rd;
    ins          = 1'b0;
    ins_idx      = bump_q;

    if (cmd_i.accept) begin
      res_status_d = ST_DONE;
      res_count_d  = '0;
      res_cards_d  = '0;
      if (in_operation_i == OP_CLEAR) begin
        bvalid_d = '0;
        free_d   = NIL;
        bump_d   = '0;
        ent_d    = '0;
        ctot_d   = '0;
      end
    end

    if (cmd_i.walk && match) begin
      case (op_q)
        OP_GET: begin
          res_count_d = pop_cnt;
          for (int k = 0; k < CARDS; k++) begin
            res_cards_d[k] = ent_rd.valid[k] ? ent_rd.cards[k] : '0;
          end
        end
        OP_CONTAINS: res_status_d = holds ? ST_DONE : ST_ABSENT;
        OP_ADD: begin
          if (holds) begin
            res_status_d = ST_PRESENT;
          end else if (!has_empty) begin
            res_status_d = ST_FULL;
          end else begin
            data_we                  = 1'b1;
            ent_wdata.valid[empty_k] = 1'b1;
            ent_wdata.cards[empty_k] = card_q;
            ctot_d                   = ctot_q + CTOT_W'(1);
          end
        end
        OP_DELETE: begin
          // Unlink from the bucket head or from the predecessor entry.
          if (prev_q[IDX_W]) begin
            head_we = 1'b1;
          end else begin
            next_we = 1'b1;
          end
          ctot_d = ctot_q - CTOT_W'(pop_cnt);
          ent_d  = ent_q - ENT_W'(1);
        end
        default: ;
      endcase
    end

    if (cmd_i.miss) begin
      if (op_q != OP_ADD) begin
        res_status_d = ST_ABSENT;
      end else if (free_q[IDX_W]) begin
        if (bump_ok) begin
          ins     = 1'b1;
          ins_idx = bump_q;
          bump_d  = bump_q + IDX_W'(1);
        end else begin
          res_status_d = ST_NOFREE;
        end
      end
    end

    if (cmd_i.pop) begin
      ins     = 1'b1;
      ins_idx = free_q[IDX_W-1:0];
      free_d  = next_rdata;
    end

    if (ins) begin
      // A new entry goes to the chain front with the card in its first slot.
      data_we            = 1'b1;
      data_waddr         = ins_idx;
      ent_wdata.region   = region_q;
      ent_wdata.valid    = CARDS'(1);
      ent_wdata.cards    = '0;
      ent_wdata.cards[0] = card_q;
      next_we            = 1'b1;
      next_waddr         = ins_idx;
      next_wdata         = head_q;
      head_we            = 1'b1;
      head_wdata         = {1'b0, ins_idx};
      bvalid_d[bucket_q] = 1'b1;
      ent_d              = ent_q + ENT_W'(1);
      ctot_d             = ctot_q + CTOT_W'(1);
    end

    if (cmd_i.del2) begin
      next_we    = 1'b1;
      next_waddr = cur_q;
      next_wdata = free_q;
      free_d     = {1'b0, cur_q};
    end
  end

  chst_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (in_region_i[IDX_W-1:0]),
    .rdata_o (head_rdata)
  );

  chst_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (entry_raddr),
    .rdata_o (next_rdata)
  );

  chst_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (entry_raddr),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= '0;
      free_q   <= NIL;
      bump_q   <= '0;
      ent_q    <= '0;
      ctot_q   <= '0;
    end else begin
      bvalid_q <= bvalid_d;
      free_q   <= free_d;
      bump_q   <= bump_d;
      ent_q    <= ent_d;
      ctot_q   <= ctot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_cards_q  <= res_cards_d;
    if (cmd_i.accept) begin
      op_q     <= in_operation_i;
      region_q <= in_region_i;
      card_q   <= in_card_i;
    end
    if (cmd_i.head) begin
      head_q <= head_val;
      cur_q  <= head_val[IDX_W-1:0];
      prev_q <= NIL;
    end
    if (cmd_i.walk && !match) begin
      prev_q <= {1'b0, cur_q};
      cur_q  <= next_rdata[IDX_W-1:0];
    end
    if (cmd_i.resp_load) begin
      out_status_q <= res_status_q;
      out_count_q  <= res_count_q;
      out_cards_q  <= res_cards_q;
      out_ent_q    <= ent_q;
      out_ctot_q   <= ctot_q;
    end
  end

  assign status_o       = out_status_q;
  assign card_count_o   = out_count_q;
  assign card_0_o       = out_cards_q[0];
  assign card_1_o       = out_cards_q[1];
  assign card_2_o       = out_cards_q[2];
  assign card_3_o       = out_cards_q[3];
  assign entries_used_o = out_ent_q;
  assign cards_used_o   = out_ctot_q;
endmodule
